// ----- rtl/gfi_pkg.sv -----
// ----------------------------------------------------------------------------
// gfi_pkg: shared types and constants for the p448 field inverter
// Holds the payload structs, the sequencer control bundle, the register file
// addresses and the microcode program of the Fermat addition chain.
// ----------------------------------------------------------------------------
package gfi_pkg;

  localparam int WORD_W  = 64;
  localparam int NWORDS  = 7;
  localparam int ELEM_W  = WORD_W * NWORDS;   // 448
  localparam int PROD_W  = 2 * ELEM_W;        // 896
  localparam int DIG_W   = 32;
  localparam int NDIG    = ELEM_W / DIG_W;    // 14
  localparam int HALF_W  = ELEM_W / 2;        // 224

  // all ones except bit 224
  localparam logic [ELEM_W-1:0] P448 =
    {{(HALF_W-1){1'b1}}, 1'b0, {HALF_W{1'b1}}};

  // register file addresses
  localparam int RADDR_W = 4;
  localparam logic [RADDR_W-1:0] R_E    = 4'd0;
  localparam logic [RADDR_W-1:0] R_T    = 4'd1;
  localparam logic [RADDR_W-1:0] R_B3   = 4'd2;
  localparam logic [RADDR_W-1:0] R_B9   = 4'd3;
  localparam logic [RADDR_W-1:0] R_B18  = 4'd4;
  localparam logic [RADDR_W-1:0] R_B37  = 4'd5;
  localparam logic [RADDR_W-1:0] R_B111 = 4'd6;
  localparam logic [RADDR_W-1:0] R_B223 = 4'd7;
  localparam logic [RADDR_W-1:0] R_Q224 = 4'd8;
  localparam int NREGS = 9;

  // repeat counts of the squaring runs
  localparam int REP_W = 8;
  localparam logic [REP_W-1:0] REP_1   = 8'd1;
  localparam logic [REP_W-1:0] REP_2   = 8'd2;
  localparam logic [REP_W-1:0] REP_3   = 8'd3;
  localparam logic [REP_W-1:0] REP_8   = 8'd8;
  localparam logic [REP_W-1:0] REP_18  = 8'd18;
  localparam logic [REP_W-1:0] REP_36  = 8'd36;
  localparam logic [REP_W-1:0] REP_37  = 8'd37;
  localparam logic [REP_W-1:0] REP_110 = 8'd110;
  localparam logic [REP_W-1:0] REP_224 = 8'd224;

  localparam int PC_W = 5;

  typedef struct packed {
    logic [WORD_W-1:0] elem_word6;
    logic [WORD_W-1:0] elem_word5;
    logic [WORD_W-1:0] elem_word4;
    logic [WORD_W-1:0] elem_word3;
    logic [WORD_W-1:0] elem_word2;
    logic [WORD_W-1:0] elem_word1;
    logic [WORD_W-1:0] elem_word0;
  } elem_t;

  typedef struct packed {
    logic [WORD_W-1:0] inv_word6;
    logic [WORD_W-1:0] inv_word5;
    logic [WORD_W-1:0] inv_word4;
    logic [WORD_W-1:0] inv_word3;
    logic [WORD_W-1:0] inv_word2;
    logic [WORD_W-1:0] inv_word1;
    logic [WORD_W-1:0] inv_word0;
  } inv_t;

  // one microcode word: dst = srca * srcb mod p, run rep times
  typedef struct packed {
    logic [RADDR_W-1:0] dst;
    logic [RADDR_W-1:0] srca;
    logic [RADDR_W-1:0] srcb;
    logic [REP_W-1:0]   rep;
    logic               last;
  } uword_t;

  // sequencer to datapath control bundle
  typedef struct packed {
    logic [RADDR_W-1:0] rd_a;
    logic [RADDR_W-1:0] rd_b;
    logic               mul_start;
    logic               wr_en;
    logic [RADDR_W-1:0] wr_addr;
    logic               fin;
    logic               busy;
  } ctl_t;

  function automatic uword_t uw(input logic [RADDR_W-1:0] d, input logic [RADDR_W-1:0] a,
                                input logic [RADDR_W-1:0] b, input logic [REP_W-1:0] r,
                                input logic l);
    uword_t w;
    w.dst  = d;
    w.srca = a;
    w.srcb = b;
    w.rep  = r;
    w.last = l;
    return w;
  endfunction

  // addition chain for e^(p-2)
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = uw(R_T,    R_E,    R_E,    REP_1,   1'b0);
      5'd1:    w = uw(R_T,    R_T,    R_E,    REP_1,   1'b0);
      5'd2:    w = uw(R_T,    R_T,    R_T,    REP_1,   1'b0);
      5'd3:    w = uw(R_B3,   R_T,    R_E,    REP_1,   1'b0);
      5'd4:    w = uw(R_T,    R_B3,   R_B3,   REP_1,   1'b0);
      5'd5:    w = uw(R_T,    R_T,    R_T,    REP_2,   1'b0);
      5'd6:    w = uw(R_T,    R_T,    R_B3,   REP_1,   1'b0);
      5'd7:    w = uw(R_T,    R_T,    R_T,    REP_3,   1'b0);
      5'd8:    w = uw(R_B9,   R_T,    R_B3,   REP_1,   1'b0);
      5'd9:    w = uw(R_T,    R_B9,   R_B9,   REP_1,   1'b0);
      5'd10:   w = uw(R_T,    R_T,    R_T,    REP_8,   1'b0);
      5'd11:   w = uw(R_B18,  R_T,    R_B9,   REP_1,   1'b0);
      5'd12:   w = uw(R_T,    R_B18,  R_B18,  REP_1,   1'b0);
      5'd13:   w = uw(R_T,    R_T,    R_E,    REP_1,   1'b0);
      5'd14:   w = uw(R_T,    R_T,    R_T,    REP_18,  1'b0);
      5'd15:   w = uw(R_B37,  R_T,    R_B18,  REP_1,   1'b0);
      5'd16:   w = uw(R_T,    R_B37,  R_B37,  REP_1,   1'b0);
      5'd17:   w = uw(R_T,    R_T,    R_T,    REP_36,  1'b0);
      5'd18:   w = uw(R_T,    R_T,    R_B37,  REP_1,   1'b0);
      5'd19:   w = uw(R_T,    R_T,    R_T,    REP_37,  1'b0);
      5'd20:   w = uw(R_B111, R_T,    R_B37,  REP_1,   1'b0);
      5'd21:   w = uw(R_T,    R_B111, R_B111, REP_1,   1'b0);
      5'd22:   w = uw(R_T,    R_T,    R_T,    REP_110, 1'b0);
      5'd23:   w = uw(R_T,    R_T,    R_B111, REP_1,   1'b0);
      5'd24:   w = uw(R_T,    R_T,    R_T,    REP_1,   1'b0);
      5'd25:   w = uw(R_B223, R_T,    R_E,    REP_1,   1'b0);
      5'd26:   w = uw(R_Q224, R_T,    R_T,    REP_1,   1'b0);
      5'd27:   w = uw(R_T,    R_B223, R_B223, REP_1,   1'b0);
      5'd28:   w = uw(R_T,    R_T,    R_T,    REP_224, 1'b0);
      5'd29:   w = uw(R_T,    R_T,    R_Q224, REP_1,   1'b0);
      5'd30:   w = uw(R_T,    R_T,    R_E,    REP_1,   1'b1);
      default: w = uw(R_T,    R_T,    R_T,    REP_1,   1'b1);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/gfi_mul.sv -----
// ----------------------------------------------------------------------------
// gfi_mul: 448-bit modular multiplier mod 2^448 - 2^224 - 1
// Digit-serial Horner product, 32 bits of b per cycle over 14 lanes, then
// four folds with 2^448 = 2^224 + 1 and one conditional subtract of p.
// ----------------------------------------------------------------------------
module gfi_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gfi_pkg::ELEM_W-1:0] a,
  input  logic [gfi_pkg::ELEM_W-1:0] b,
  output logic                      done,
  output logic [gfi_pkg::ELEM_W-1:0] res
);
  import gfi_pkg::*;

  localparam int CNT_W = $clog2(NDIG);
  localparam int PP_W  = ELEM_W + DIG_W;

  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_MULT  = 5'b00010,
    M_DRAIN = 5'b00100,
    M_FOLD  = 5'b01000,
    M_SUB   = 5'b10000
  } mstate_t;

  mstate_t state;
  logic [ELEM_W-1:0] a_reg;
  logic [ELEM_W-1:0] b_reg;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        fcnt;
  logic              p1_v;
  logic              p2_v;
  logic [2*DIG_W-1:0] prod [NDIG];
  logic [PP_W-1:0]   pp;
  logic [PROD_W-1:0] acc;

  logic [ELEM_W-1:0] even_cat;
  logic [ELEM_W-1:0] odd_cat;
  logic [PP_W-1:0]   pp_next;
  logic [PROD_W-1:0] mac_next;
  logic [PROD_W-1:0] fold_next;
  logic [ELEM_W:0]   diff;

  always_comb begin
    for (int k = 0; k < NDIG / 2; k++) begin
      even_cat[2*DIG_W*k +: 2*DIG_W] = prod[2*k];
      odd_cat[2*DIG_W*k +: 2*DIG_W]  = prod[2*k+1];
    end
    pp_next   = {{DIG_W{1'b0}}, even_cat} + {odd_cat, {DIG_W{1'b0}}};
    mac_next  = {acc[PROD_W-DIG_W-1:0], {DIG_W{1'b0}}}
              + {{(PROD_W-PP_W){1'b0}}, pp};
    fold_next = {{ELEM_W{1'b0}}, acc[ELEM_W-1:0]}
              + {{ELEM_W{1'b0}}, acc[PROD_W-1:ELEM_W]}
              + {{HALF_W{1'b0}}, acc[PROD_W-1:ELEM_W], {HALF_W{1'b0}}};
    diff      = {1'b0, acc[ELEM_W-1:0]} - {1'b0, P448};
  end

  // lane products of a against the top digit of b
  for (genvar i = 0; i < NDIG; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (state == M_MULT) begin
        prod[i] <= a_reg[DIG_W*i +: DIG_W] * b_reg[ELEM_W-1 -: DIG_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
      done  <= 1'b0;
    end else begin
      p1_v <= (state == M_MULT);
      p2_v <= p1_v;
      done <= (state == M_SUB);
      unique case (state)
        M_IDLE: begin
          if (start) begin
            state <= M_MULT;
          end
        end
        M_MULT: begin
          if (cnt == CNT_W'(NDIG - 1)) begin
            state <= M_DRAIN;
          end
        end
        M_DRAIN: begin
          if (!p1_v && !p2_v) begin
            state <= M_FOLD;
          end
        end
        M_FOLD: begin
          if (fcnt == 2'd3) begin
            state <= M_SUB;
          end
        end
        M_SUB: begin
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (p1_v) begin
      pp <= pp_next;
    end
    case (state)
      M_IDLE: begin
        a_reg <= a;
        b_reg <= b;
        acc   <= '0;
        cnt   <= '0;
        fcnt  <= '0;
      end
      M_MULT: begin
        b_reg <= {b_reg[ELEM_W-DIG_W-1:0], {DIG_W{1'b0}}};
        cnt   <= cnt + 1'b1;
      end
      M_FOLD: begin
        acc  <= fold_next;
        fcnt <= fcnt + 1'b1;
      end
      M_SUB: begin
        res <= diff[ELEM_W] ? acc[ELEM_W-1:0] : diff[ELEM_W-1:0];
      end
      default: ;
    endcase
    if (p2_v) begin
      acc <= mac_next;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == M_IDLE)
    else $error("multiply started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done longer than one cycle");

  a_fold_clean: assert property (@(posedge clk) disable iff (rst)
    state == M_FOLD |-> !p1_v && !p2_v)
    else $error("fold while products still in flight");

endmodule

// ----- rtl/gfi_seq.sv -----
// ----------------------------------------------------------------------------
// gfi_seq: microcode sequencer for the inversion chain
// Steps through the program table, repeats a step in place for squaring
// runs, and issues register reads, multiplier starts and writebacks.
// ----------------------------------------------------------------------------
module gfi_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          mul_done,
  output gfi_pkg::ctl_t ctl
);
  import gfi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_LOAD = 4'b0100,
    S_WAIT = 4'b1000
  } sstate_t;

  sstate_t          state;
  logic [PC_W-1:0]  pc;
  logic [REP_W-1:0] rep;
  uword_t           word;
  uword_t           word_nx;
  uword_t           word_0;

  assign word    = ucode(pc);
  assign word_nx = ucode(pc + 1'b1);
  assign word_0  = ucode('0);

  always_comb begin
    ctl.rd_a      = word.srca;
    ctl.rd_b      = word.srcb;
    ctl.mul_start = (state == S_LOAD);
    ctl.wr_en     = (state == S_WAIT) && mul_done;
    ctl.wr_addr   = word.dst;
    ctl.fin       = (state == S_WAIT) && mul_done && (rep == REP_1) && word.last;
    ctl.busy      = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      rep   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pc    <= '0;
            rep   <= word_0.rep;
            state <= S_READ;
          end
        end
        S_READ: state <= S_LOAD;
        S_LOAD: state <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            if (rep != REP_1) begin
              rep   <= rep - 1'b1;
              state <= S_READ;
            end else if (word.last) begin
              state <= S_IDLE;
            end else begin
              pc    <= pc + 1'b1;
              rep   <= word_nx.rep;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> rep != '0)
    else $error("step issued with empty repeat count");

  a_start_follows_read: assert property (@(posedge clk) disable iff (rst)
    ctl.mul_start |-> $past(state) == S_READ)
    else $error("multiply started without a register read");

  a_wr_in_wait: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |=> state == S_READ || state == S_IDLE)
    else $error("writeback not followed by next step or end");

endmodule

// ----- rtl/gf_p448_field_inverse.sv -----
// ----------------------------------------------------------------------------
// gf_p448_field_inverse: inverse in GF(2^448 - 2^224 - 1)
// Computes e^(p-2) mod p with a fixed addition chain run by a microcoded
// sequencer over a nine-entry register file and one modular multiplier.
// ----------------------------------------------------------------------------
//
//  channel | ports                  | transfer
//  --------+------------------------+------------------------------------
//  input   | start, busy, elem      | start high while busy low
//  result  | done, inv              | done high for one cycle
//
// Each item runs 461 modular multiplies/squarings back to back. One multiply
// runs register read, operand load, the digit loop through the 14-lane
// multiplier, pipeline drain, four folds, the final subtract of p and the
// done handoff. Reset clears the sequencer and the multiplier control; the
// register file needs no clearing since every entry is written before it is
// read. The result cannot be stalled: inv is valid only in the cycle that
// done is high, and a new item may start in that same cycle.
//
module gf_p448_field_inverse (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  gfi_pkg::elem_t elem,
  output logic           done,
  output gfi_pkg::inv_t  inv
);
  import gfi_pkg::*;

  ctl_t              ctl;
  logic              mul_done;
  logic [ELEM_W-1:0] mul_res;
  logic [ELEM_W-1:0] rd_a_data;
  logic [ELEM_W-1:0] rd_b_data;
  logic              accept;

  // register file: e, t and the chain blocks
  logic [ELEM_W-1:0] regs [NREGS];

  assign accept = start && !busy;
  assign busy   = ctl.busy;

  gfi_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .mul_done (mul_done),
    .ctl      (ctl)
  );

  gfi_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.mul_start),
    .a     (rd_a_data),
    .b     (rd_b_data),
    .done  (mul_done),
    .res   (mul_res)
  );

  // write port: input element on transfer, otherwise multiplier writeback
  always_ff @(posedge clk) begin
    if (accept) begin
      regs[R_E] <= elem;
    end else if (ctl.wr_en) begin
      regs[ctl.wr_addr] <= mul_res;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rd_a_data <= regs[ctl.rd_a];
    rd_b_data <= regs[ctl.rd_b];
  end

  // hold the final product for its one-cycle strobe
  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      inv <= mul_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.fin;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("transfer did not start the sequence");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results for one item");

endmodule

// ----- tb/sv/gf_p448_field_inverse_chk.sv -----
// ----------------------------------------------------------------------------
// gf_p448_field_inverse_chk: result checker for the p448 field inverter
// Watches the command and result channels. For every accepted element it
// works out the expected inverse by square-and-multiply on wide vectors, then
// compares each result word against the oldest expected inverse.
// ----------------------------------------------------------------------------
module gf_p448_field_inverse_chk (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  gfi_pkg::elem_t elem,
  input  logic           done,
  input  gfi_pkg::inv_t  inv,
  output int             fail_cnt,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gfi_pkg::*;

  inv_t inv_q[$];

  function automatic logic [ELEM_W-1:0] mod_mul(input logic [ELEM_W-1:0] a,
                                                input logic [ELEM_W-1:0] b);
    logic [PROD_W-1:0] prod;
    prod = {{ELEM_W{1'b0}}, a} * {{ELEM_W{1'b0}}, b};
    prod = prod % {{ELEM_W{1'b0}}, P448};
    return prod[ELEM_W-1:0];
  endfunction

  // e^(p-2) mod p, with an input of p or more reduced first
  function automatic inv_t field_inverse(input elem_t e);
    logic [ELEM_W-1:0] base;
    logic [ELEM_W-1:0] acc;
    logic [ELEM_W-1:0] pw;
    base = e;
    if (base >= P448) base = base - P448;
    pw  = P448 - 2;
    acc = 1;
    for (int i = ELEM_W - 1; i >= 0; i--) begin
      acc = mod_mul(acc, acc);
      if (pw[i]) acc = mod_mul(acc, base);
    end
    return inv_t'(acc);
  endfunction

  assign pending = inv_q.size();

  always @(posedge clk) begin
    inv_t want;
    logic [ELEM_W-1:0] w_bits;
    logic [ELEM_W-1:0] g_bits;
    if (rst) begin
      fail_cnt <= 0;
    end else begin
      if (start && !busy) inv_q.push_back(field_inverse(elem));
      if (done) begin
        if (inv_q.size() == 0) begin
          $error("result with no element outstanding: %h", inv);
          fail_cnt <= fail_cnt + 1;
        end else begin
          want   = inv_q.pop_front();
          w_bits = want;
          g_bits = inv;
          if (w_bits != g_bits) begin
            for (int i = 0; i < NWORDS; i++)
              if (w_bits[i*WORD_W +: WORD_W] != g_bits[i*WORD_W +: WORD_W])
                $error("inv_word%0d: expected %h, got %h", i,
                       w_bits[i*WORD_W +: WORD_W], g_bits[i*WORD_W +: WORD_W]);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/gf_p448_field_inverse_tb.sv -----
// ----------------------------------------------------------------------------
// gf_p448_field_inverse_tb: top-level testbench for the p448 field inverter
// Drives directed edge elements, then random elements with random gaps, and
// leaves all prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module gf_p448_field_inverse_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gfi_pkg::*;

  localparam int N_RAND     = 300;
  // watchdog limit: allow a wide margin over one inversion
  localparam int IDLE_LIMIT = 60000;
  localparam int DRAIN_CYC  = 50;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  elem_t elem = '0;
  logic  done;
  inv_t  inv;
  int    fail_cnt;
  int    pending;
  int    idle_cyc = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gf_p448_field_inverse u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .elem  (elem),
    .done  (done),
    .inv   (inv)
  );

  gf_p448_field_inverse_chk u_chk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .elem     (elem),
    .done     (done),
    .inv      (inv),
    .fail_cnt (fail_cnt),
    .pending  (pending)
  );

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic [ELEM_W-1:0] rand_elem();
    logic [ELEM_W-1:0] v;
    for (int i = 0; i < NWORDS * 2; i++) v[i*DIG_W +: DIG_W] = $urandom;
    return v;
  endfunction

  // Present one element, hold it until the block takes it, then idle.
  // Keep start high across back-to-back transfers; never drop and re-raise it.
  task automatic send_elem(input logic [ELEM_W-1:0] v, input int gap);
    start <= 1'b1;
    elem  <= elem_t'(v);
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [ELEM_W-1:0] v;
    int gap;
    int quiet;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, one, two, p and its neighbors, all ones, lone bits, alternating bits and lone words.
    send_elem('0, 0);
    send_elem(1, 1);
    send_elem(2, 0);
    send_elem(P448 - 1, 3);
    send_elem(P448 - 2, 0);
    send_elem(P448, 2);
    send_elem(P448 + 1, 0);
    send_elem(P448 + 2, 5);
    send_elem({ELEM_W{1'b1}}, 0);
    send_elem({ELEM_W{1'b1}} - 1, 0);
    send_elem(ELEM_W'(1) << HALF_W, 1);
    send_elem(ELEM_W'(1) << (ELEM_W - 1), 0);
    send_elem({(ELEM_W/2){2'b10}}, 4);
    send_elem({(ELEM_W/2){2'b01}}, 0);
    for (int i = 0; i < NWORDS; i++) begin
      v = '0;
      v[i*WORD_W +: WORD_W] = {WORD_W{1'b1}};
      send_elem(v, i % 3);
    end

    // Random: mostly full-range words, some just above or below p, some small 64-bit values.
    quiet = 0;
    for (int n = 0; n < N_RAND; n++) begin
      case ($urandom_range(0, 9))
        0:       v = P448 + ELEM_W'($urandom_range(0, 1000));
        1:       v = P448 - ELEM_W'($urandom_range(1, 1000));
        2:       v = ELEM_W'({$urandom, $urandom});
        default: v = rand_elem();
      endcase
      // stretches with no gaps between items
      if (quiet == 0 && $urandom_range(0, 9) == 0) quiet = $urandom_range(5, 20);
      if (quiet > 0) begin
        quiet--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 5);
      end
      send_elem(v, gap);
    end
    start <= 1'b0;

    // Drain: wait for every expected inverse, then let the bench settle before the verdict.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
